@@ hdl/nand_page_state_table_assert.svh @@
// assertion macros for the nand page state table
`ifndef NAND_PAGE_STATE_TABLE_ASSERT_SVH
`define NAND_PAGE_STATE_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define NPST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define NPST_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define NPST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define NPST_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ hdl/npst_pkg.sv @@
// shared widths, codes and types of the nand page state table
package npst_pkg;

	localparam int PIB_DEF         = 64;
	localparam int BLOCK_COUNT_DEF = 1024;

	localparam int OP_W    = 2;
	localparam int PA_W    = 17;
	localparam int BA_W    = 11;
	localparam int LBA_W   = 32;
	localparam int ST_W    = 2;
	localparam int STAT_W  = 2;
	localparam int PW_W    = 16;
	localparam int INVO_W  = 7;
	localparam int ERS_W   = 32;
	localparam int FREEO_W = 17;
	localparam int TOT_W   = 32;

	localparam int RAM_W_DEF     = 8;
	localparam int RAM_DEPTH_DEF = 16;

	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_ERASE = 2'd2;
	localparam logic [OP_W-1:0] OP_SET   = 2'd3;

	localparam logic [ST_W-1:0] PG_FREE    = 2'd0;
	localparam logic [ST_W-1:0] PG_VALID   = 2'd1;
	localparam logic [ST_W-1:0] PG_INVALID = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_RANGE     = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOT_FREE  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_NOT_VALID = 2'd3;

	localparam logic [LBA_W-1:0] ERASED_LBA = 32'hFFFF_FFFF;
	localparam logic [PW_W-1:0]  WRITES_MAX = 16'hFFFF;

	// one page table entry
	typedef struct packed {
		logic [ST_W-1:0]  state;
		logic [LBA_W-1:0] lba;
		logic [PW_W-1:0]  writes;
	} npst_page_t;

	localparam int PAGE_ENT_W = ST_W + LBA_W + PW_W;

	localparam npst_page_t ERASED_PAGE = '{state: PG_FREE, lba: ERASED_LBA, writes: 16'h0000};

	// one response
	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [ST_W-1:0]    page_state;
		logic [LBA_W-1:0]   stored_logical_address;
		logic [PW_W-1:0]    page_writes;
		logic [INVO_W-1:0]  block_invalid_pages;
		logic [ERS_W-1:0]   block_erases;
		logic [FREEO_W-1:0] free_page_count;
		logic [TOT_W-1:0]   write_total;
		logic [TOT_W-1:0]   erase_total;
	} npst_res_t;

endpackage

@@ hdl/nand_page_state_table.sv @@
// top level of the nand page state table: control, counters and table rams
//
// request channel: in_valid / in_stall with opcode, page_address, block_address,
// logical_address and new_state; a request is taken when in_valid is high and
// in_stall is low. response channel: out_valid / out_stall, one response per
// request, in request order.
// page metadata (state, logical address, write count) sits in one ram of
// PAGES_IN_BLOCK * BLOCK_COUNT words, block metadata (erase count, invalid
// count) in a second ram of BLOCK_COUNT words, both with registered reads.
// write, read and set state: accept, block index by reciprocal multiply, ram
// read, modify and write back (read writes nothing), response staging; the
// next request is taken only after the response has been staged.
// erase: one page read and one cleared write per cycle through the block,
// both on the single page ram port pair.
// out-of-range requests skip the rams.
// after reset a clearing pass writes every page word (and the block words)
// to their erased values, PAGES_IN_BLOCK * BLOCK_COUNT page words, 65536 by
// default; in_stall stays high until the pass ends.
// a stalled response waits in the output register; the next request is
// still taken and processed, then held until that register frees up.
`include "nand_page_state_table_assert.svh"

module nand_page_state_table #(
	parameter int PAGES_IN_BLOCK = npst_pkg::PIB_DEF,
	parameter int BLOCK_COUNT    = npst_pkg::BLOCK_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [npst_pkg::OP_W-1:0]     opcode,
	input  logic [npst_pkg::PA_W-1:0]     page_address,
	input  logic [npst_pkg::BA_W-1:0]     block_address,
	input  logic [npst_pkg::LBA_W-1:0]    logical_address,
	input  logic [npst_pkg::ST_W-1:0]     new_state,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [npst_pkg::STAT_W-1:0]   status,
	output logic [npst_pkg::ST_W-1:0]     page_state,
	output logic [npst_pkg::LBA_W-1:0]    stored_logical_address,
	output logic [npst_pkg::PW_W-1:0]     page_writes,
	output logic [npst_pkg::INVO_W-1:0]   block_invalid_pages,
	output logic [npst_pkg::ERS_W-1:0]    block_erases,
	output logic [npst_pkg::FREEO_W-1:0]  free_page_count,
	output logic [npst_pkg::TOT_W-1:0]    write_total,
	output logic [npst_pkg::TOT_W-1:0]    erase_total
);

	localparam int PAGE_TOTAL = PAGES_IN_BLOCK * BLOCK_COUNT;
	localparam int PAGE_AW    = $clog2(PAGE_TOTAL);
	localparam int BLK_AW     = $clog2(BLOCK_COUNT);
	localparam int FREE_W     = $clog2(PAGE_TOTAL + 1);
	localparam int INV_W      = $clog2(PAGES_IN_BLOCK + 1);
	localparam int WC_W       = $clog2(PAGES_IN_BLOCK + 1);
	localparam int BK_W       = npst_pkg::ERS_W + INV_W;
	// block index = floor(page * DIV_MULT / 2^DIV_SHIFT), exact for every page input
	localparam int MULT_W     = npst_pkg::PA_W + 2;
	localparam int PROD_W     = npst_pkg::PA_W + MULT_W;
	localparam int DIV_SHIFT  = npst_pkg::PA_W + $clog2(PAGES_IN_BLOCK);
	localparam longint unsigned DIV_MULT =
		((64'd1 << DIV_SHIFT) + PAGES_IN_BLOCK - 1) / PAGES_IN_BLOCK;

	localparam logic [2:0] S_CLR   = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_MUL   = 3'd2;
	localparam logic [2:0] S_RD    = 3'd3;
	localparam logic [2:0] S_MOD   = 3'd4;
	localparam logic [2:0] S_EWALK = 3'd5;
	localparam logic [2:0] S_EFIN  = 3'd6;
	localparam logic [2:0] S_OUT   = 3'd7;

	// control state
	logic [2:0]                      state_q;
	logic [PAGE_AW-1:0]              clr_q;
	logic                            rng_q;
	logic [WC_W-1:0]                 wc_q;
	logic                            pend_s1;
	logic [FREE_W-1:0]               free_q;
	logic [npst_pkg::TOT_W-1:0]      wtot_q;
	logic [npst_pkg::TOT_W-1:0]      etot_q;

	// request and working payload
	logic [npst_pkg::OP_W-1:0]       op_q;
	logic [npst_pkg::PA_W-1:0]       pg_q;
	logic [npst_pkg::BA_W-1:0]       blk_q;
	logic [npst_pkg::LBA_W-1:0]      lba_q;
	logic [npst_pkg::ST_W-1:0]       ns_q;
	logic [PROD_W-1:0]               prod_q;
	logic [BLK_AW-1:0]               bidx_q;
	logic [PAGE_AW-1:0]              wa_s1;
	npst_pkg::npst_res_t             res_q;

	// ram ports
	logic                            pm_we;
	logic [PAGE_AW-1:0]              pm_wa;
	npst_pkg::npst_page_t            pm_wd;
	logic                            pm_re;
	logic [PAGE_AW-1:0]              pm_ra;
	npst_pkg::npst_page_t            pm_rd;
	logic                            bm_we;
	logic [BLK_AW-1:0]               bm_wa;
	logic [BK_W-1:0]                 bm_wd;
	logic                            bm_re;
	logic [BLK_AW-1:0]               bm_ra;
	logic [BK_W-1:0]                 bm_rd;

	// datapath
	logic [PAGE_AW-1:0]              pidx;
	logic [BLK_AW-1:0]               quot;
	logic [PAGE_AW-1:0]              ebase;
	logic [npst_pkg::PA_W-1:0]       mul_a;
	logic [MULT_W-1:0]               mul_b;
	logic [PROD_W-1:0]               prod_d;
	logic                            rng_d;
	logic                            walk_re;
	logic [npst_pkg::ERS_W-1:0]      bk_ers;
	logic [INV_W-1:0]                bk_inv;
	logic [FREE_W-1:0]               free_d;
	logic [npst_pkg::TOT_W-1:0]      wtot_d;
	logic [npst_pkg::TOT_W-1:0]      etot_d;
	npst_pkg::npst_res_t             res_d;
	logic                            out_free;
	logic                            out_load;
	npst_pkg::npst_res_t             out_res;

	assign in_stall = (state_q != S_IDLE);

	assign pidx   = PAGE_AW'(pg_q);
	assign quot   = BLK_AW'(prod_q >> DIV_SHIFT);
	assign ebase  = PAGE_AW'(prod_q);
	assign bk_ers = bm_rd[BK_W-1:INV_W];
	assign bk_inv = bm_rd[INV_W-1:0];

	// one shared multiplier: block base for erase, reciprocal for block index
	assign mul_a  = (op_q == npst_pkg::OP_ERASE) ? npst_pkg::PA_W'(blk_q) : pg_q;
	assign mul_b  = (op_q == npst_pkg::OP_ERASE) ? MULT_W'(PAGES_IN_BLOCK) : MULT_W'(DIV_MULT);
	assign prod_d = mul_a * mul_b;

	assign rng_d = (op_q == npst_pkg::OP_ERASE) ? (32'(blk_q) >= 32'(BLOCK_COUNT))
		: (32'(pg_q) >= 32'(PAGE_TOTAL));

	assign walk_re = (32'(wc_q) < 32'(PAGES_IN_BLOCK));

	always_comb begin
		logic [npst_pkg::ST_W-1:0]   old_st;
		npst_pkg::npst_page_t        rep_pg;
		logic [INV_W-1:0]            rep_inv;
		logic [npst_pkg::ERS_W-1:0]  rep_ers;
		logic [npst_pkg::STAT_W-1:0] stat;

		pm_we  = 1'b0;
		pm_wa  = pidx;
		pm_wd  = pm_rd;
		pm_re  = 1'b0;
		pm_ra  = pidx;
		bm_we  = 1'b0;
		bm_wa  = bidx_q;
		bm_wd  = bm_rd;
		bm_re  = 1'b0;
		bm_ra  = quot;
		free_d = free_q;
		wtot_d = wtot_q;
		etot_d = etot_q;
		res_d  = '0;
		old_st  = pm_rd.state;
		rep_pg  = pm_rd;
		rep_inv = bk_inv;
		rep_ers = bk_ers;
		stat    = npst_pkg::STAT_OK;

		unique case (state_q)
			S_CLR: begin
				// clearing pass, one page word a cycle, plus one block word while below BLOCK_COUNT
				pm_we = 1'b1;
				pm_wa = clr_q;
				pm_wd = npst_pkg::ERASED_PAGE;
				bm_we = (32'(clr_q) < 32'(BLOCK_COUNT));
				bm_wa = BLK_AW'(clr_q);
				bm_wd = '0;
			end
			S_IDLE, S_MUL, S_OUT: begin
			end
			S_RD: begin
				pm_re = 1'b1;
				bm_re = 1'b1;
			end
			S_EWALK: begin
				pm_re = walk_re;
				pm_ra = ebase + PAGE_AW'(wc_q);
				bm_re = (wc_q == '0);
				bm_ra = BLK_AW'(blk_q);
			end
			S_MOD: begin
				if (rng_q) begin
					stat    = npst_pkg::STAT_RANGE;
					rep_pg  = npst_pkg::ERASED_PAGE;
					rep_inv = '0;
					rep_ers = '0;
				end else begin
					unique case (op_q)
						npst_pkg::OP_WRITE: begin
							if (old_st != npst_pkg::PG_FREE) begin
								stat = npst_pkg::STAT_NOT_FREE;
							end else begin
								rep_pg.state = npst_pkg::PG_VALID;
								rep_pg.lba   = lba_q;
								if (pm_rd.writes != npst_pkg::WRITES_MAX) begin
									rep_pg.writes = pm_rd.writes + 16'd1;
								end
								pm_we  = 1'b1;
								pm_wd  = rep_pg;
								wtot_d = wtot_q + 32'd1;
								if (free_q != '0) begin
									free_d = free_q - FREE_W'(1);
								end
							end
						end
						npst_pkg::OP_READ: begin
							stat = (old_st == npst_pkg::PG_VALID) ? npst_pkg::STAT_OK
								: npst_pkg::STAT_NOT_VALID;
						end
						npst_pkg::OP_SET: begin
							// unused state code leaves everything as it is
							if (ns_q <= npst_pkg::PG_INVALID) begin
								rep_pg.state = ns_q;
								pm_we = 1'b1;
								pm_wd = rep_pg;
								if (old_st != npst_pkg::PG_INVALID
									&& ns_q == npst_pkg::PG_INVALID) begin
									if (32'(bk_inv) < 32'(PAGES_IN_BLOCK)) begin
										rep_inv = bk_inv + INV_W'(1);
									end
								end else if (old_st == npst_pkg::PG_INVALID
									&& ns_q != npst_pkg::PG_INVALID) begin
									if (bk_inv != '0) begin
										rep_inv = bk_inv - INV_W'(1);
									end
								end
								bm_we = 1'b1;
								bm_wd = {bk_ers, rep_inv};
								if (old_st == npst_pkg::PG_FREE && ns_q != npst_pkg::PG_FREE) begin
									if (free_q != '0) begin
										free_d = free_q - FREE_W'(1);
									end
								end else if (old_st != npst_pkg::PG_FREE
									&& ns_q == npst_pkg::PG_FREE) begin
									if (32'(free_q) < 32'(PAGE_TOTAL)) begin
										free_d = free_q + FREE_W'(1);
									end
								end
							end
						end
						npst_pkg::OP_ERASE: begin
							// in-range erase runs through the walk states
						end
					endcase
				end
				res_d.status                 = stat;
				res_d.page_state             = rep_pg.state;
				res_d.stored_logical_address = rep_pg.lba;
				res_d.page_writes            = rep_pg.writes;
				res_d.block_invalid_pages    = npst_pkg::INVO_W'(rep_inv);
				res_d.block_erases           = rep_ers;
				res_d.free_page_count        = npst_pkg::FREEO_W'(free_d);
				res_d.write_total            = wtot_d;
				res_d.erase_total            = etot_d;
			end
			S_EFIN: begin
				bm_we  = 1'b1;
				bm_wa  = BLK_AW'(blk_q);
				bm_wd  = {bk_ers + 32'd1, {INV_W{1'b0}}};
				etot_d = etot_q + 32'd1;
				res_d.status                 = npst_pkg::STAT_OK;
				res_d.page_state             = npst_pkg::PG_FREE;
				res_d.stored_logical_address = npst_pkg::ERASED_LBA;
				res_d.page_writes            = '0;
				res_d.block_invalid_pages    = '0;
				res_d.block_erases           = bk_ers + 32'd1;
				res_d.free_page_count        = npst_pkg::FREEO_W'(free_q);
				res_d.write_total            = wtot_q;
				res_d.erase_total            = etot_d;
			end
		endcase

		// erase walk write-back: page read last cycle is cleared now
		if (pend_s1) begin
			pm_we = 1'b1;
			pm_wa = wa_s1;
			pm_wd = npst_pkg::ERASED_PAGE;
			if (pm_rd.state != npst_pkg::PG_FREE) begin
				free_d = free_q + FREE_W'(1);
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			rng_q   <= 1'b0;
			wc_q    <= '0;
			pend_s1 <= 1'b0;
			free_q  <= FREE_W'(PAGE_TOTAL);
			wtot_q  <= '0;
			etot_q  <= '0;
		end else begin
			pend_s1 <= (state_q == S_EWALK) && walk_re;
			free_q  <= free_d;
			wtot_q  <= wtot_d;
			etot_q  <= etot_d;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + PAGE_AW'(1);
					if (clr_q == PAGE_AW'(PAGE_TOTAL - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					rng_q <= rng_d;
					wc_q  <= '0;
					if (rng_d) begin
						state_q <= S_MOD;
					end else if (op_q == npst_pkg::OP_ERASE) begin
						state_q <= S_EWALK;
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_MOD;
				end
				S_MOD: begin
					state_q <= S_OUT;
				end
				S_EWALK: begin
					if (wc_q == WC_W'(PAGES_IN_BLOCK)) begin
						state_q <= S_EFIN;
					end else begin
						wc_q <= wc_q + WC_W'(1);
					end
				end
				S_EFIN: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			op_q  <= opcode;
			pg_q  <= page_address;
			blk_q <= block_address;
			lba_q <= logical_address;
			ns_q  <= new_state;
		end
		if (state_q == S_MUL) begin
			prod_q <= prod_d;
		end
		if (state_q == S_RD) begin
			bidx_q <= quot;
		end
		if (state_q == S_MOD || state_q == S_EFIN) begin
			res_q <= res_d;
		end
		wa_s1 <= pm_ra;
	end

	npst_ram #(
		.WIDTH(npst_pkg::PAGE_ENT_W),
		.DEPTH(PAGE_TOTAL)
	) u_page_ram (
		.clk(clk),
		.we (pm_we),
		.wa (pm_wa),
		.wd (pm_wd),
		.re (pm_re),
		.ra (pm_ra),
		.rd (pm_rd)
	);

	npst_ram #(
		.WIDTH(BK_W),
		.DEPTH(BLOCK_COUNT)
	) u_block_ram (
		.clk(clk),
		.we (bm_we),
		.wa (bm_wa),
		.wd (bm_wd),
		.re (bm_re),
		.ra (bm_ra),
		.rd (bm_rd)
	);

	assign out_load = (state_q == S_OUT) && out_free;

	npst_outreg u_outreg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (out_load),
		.din      (res_q),
		.free     (out_free),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.dout     (out_res)
	);

	assign status                 = out_res.status;
	assign page_state             = out_res.page_state;
	assign stored_logical_address = out_res.stored_logical_address;
	assign page_writes            = out_res.page_writes;
	assign block_invalid_pages    = out_res.block_invalid_pages;
	assign block_erases           = out_res.block_erases;
	assign free_page_count        = out_res.free_page_count;
	assign write_total            = out_res.write_total;
	assign erase_total            = out_res.erase_total;

	`NPST_ASSERT_IMP(a_free_bound, clk, arst_n, 1'b1, 32'(free_q) <= 32'(PAGE_TOTAL), "free page count above page total")
	`NPST_ASSERT_IMP(a_walk_pend, clk, arst_n, pend_s1, state_q == S_EWALK, "erase write-back outside the walk")
	`NPST_ASSERT_IMP(a_out_rise, clk, arst_n, $rose(out_valid), $past(state_q) == S_OUT, "response appeared without staging")
	`NPST_ASSERT_IMP(a_erase_cnt, clk, arst_n, etot_q != $past(etot_q), $past(state_q) == S_EFIN, "erase total moved outside erase finish")
	`NPST_ASSERT_NXT(a_out_load, clk, arst_n, state_q == S_OUT && !out_valid, out_valid, "staged response not loaded")

endmodule

@@ hdl/npst_ram.sv @@
// simple dual-port synchronous ram, one write and one registered read port
module npst_ram #(
	parameter int WIDTH = npst_pkg::RAM_W_DEF,
	parameter int DEPTH = npst_pkg::RAM_DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    wa,
	input  logic [WIDTH-1:0] wd,
	input  logic             re,
	input  logic [AW-1:0]    ra,
	output logic [WIDTH-1:0] rd
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd_q <= mem[ra];
		end
	end

	assign rd = rd_q;

endmodule

@@ hdl/npst_outreg.sv @@
// response register between the table logic and the response channel
module npst_outreg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  npst_pkg::npst_res_t din,
	output logic               free,
	output logic               out_valid,
	input  logic               out_stall,
	output npst_pkg::npst_res_t dout
);

	logic                v_q;
	npst_pkg::npst_res_t data_q;

	// room when empty or when the held response leaves this cycle
	assign free = !v_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (load) begin
			v_q <= 1'b1;
		end else if (!out_stall) begin
			v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= din;
		end
	end

	assign out_valid = v_q;
	assign dout      = data_q;

endmodule
